>>> hw/rtl/lsdf_pkg.sv
// Shared types, constants and helpers for the lidar sample decode filter.
`timescale 1ns / 1ps

package lsdf_pkg;

	// Field widths
	localparam int DIST_W     = 16;
	localparam int ANGLE_W    = 16;
	localparam int STRENGTH_W = 8;
	localparam int SUM_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Decode: distance_mm = 10 * raw - 145, modulo 2^16
	localparam logic [DIST_W-1:0] DIST_OFFSET = 16'd145;

	// Divide by three: floor(x * RECIP3 / 2^RECIP3_SHIFT) is exact for x < 2^19
	localparam int                RECIP3_W     = 19;
	localparam logic [RECIP3_W-1:0] RECIP3     = 19'd349526;
	localparam int                RECIP3_SHIFT = 20;
	localparam int                PROD_W       = SUM_W + RECIP3_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STRENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_JUMP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_JUMP = 3'd4;

	// Register reset values
	localparam logic [STRENGTH_W-1:0] MIN_STRENGTH_RST  = 8'd60;
	localparam logic [DIST_W-1:0]     MIN_DISTANCE_RST  = 16'd300;
	localparam logic [ANGLE_W-1:0]    MAX_ANGLE_RST     = 16'd5760;
	localparam logic [ANGLE_W-1:0]    ANGLE_JUMP_RST    = 16'd2328;
	localparam logic [DIST_W-1:0]     DISTANCE_JUMP_RST = 16'd200;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// One classified record: up to three results, in order rot, held, new
	typedef struct packed {
		logic              rot_en;
		logic              rot_has;
		logic [DIST_W-1:0] rot_dist;
		logic              held_en;
		logic [DIST_W-1:0] held_dist;
		logic              new_en;
		logic              new_avg;   // new_val is a three-point sum to divide
		logic [SUM_W-1:0]  new_val;
	} lsdf_entry_t;

	function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

>>> hw/rtl/lsdf_if.sv
// Channel interfaces: record input, result output and register write port.
`timescale 1ns / 1ps

interface lsdf_in_if;
	import lsdf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  sync;
	logic [ANGLE_W-1:0]    angle_raw;
	logic [DIST_W-1:0]     distance_raw;
	logic [STRENGTH_W-1:0] strength;

	modport source(output valid, sync, angle_raw, distance_raw, strength, input ready);
	modport sink(input valid, sync, angle_raw, distance_raw, strength, output ready);
endinterface

interface lsdf_out_if;
	import lsdf_pkg::*;
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance_mm;
	logic              has_distance;
	logic              rotation_end;
	logic              last;

	modport source(output valid, distance_mm, has_distance, rotation_end, last, input ready);
	modport sink(input valid, distance_mm, has_distance, rotation_end, last, output ready);
endinterface

interface lsdf_cfg_if;
	import lsdf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/lidar_sample_decode_filter_unit.sv
// Lidar sample decode and run filter: top level.
// Path: results pass the command queue, the work register and the output register.
// Throughput: one record per cycle while the queue has room; each result leaves in turn.
// The back end emits one result per cycle while result.ready holds; the queue absorbs bursts.
// Reset: registers return to their defaults, filter history clears, queue empties.
`timescale 1ns / 1ps

module lidar_sample_decode_filter_unit #(
	parameter int QUEUE_DEPTH = lsdf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lsdf_in_if.sink     sample,
	lsdf_out_if.source  result,
	lsdf_cfg_if.sink    cfg
);
	import lsdf_pkg::*;

	logic        push;
	logic        q_full;
	logic        pop;
	logic        nonempty;
	lsdf_entry_t push_entry;
	lsdf_entry_t head;

	lsdf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	lsdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.nonempty   (nonempty)
	);

	lsdf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.result   (result)
	);

endmodule

>>> hw/rtl/lsdf_front.sv
// Front end: register file, record decode, acceptance test and run filter state.
`timescale 1ns / 1ps

module lsdf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	lsdf_in_if.sink              sample,
	lsdf_cfg_if.sink             cfg,
	input  logic                 q_full,
	output logic                 push,
	output lsdf_pkg::lsdf_entry_t entry
);
	import lsdf_pkg::*;

	logic [STRENGTH_W-1:0] min_strength_q;
	logic [DIST_W-1:0]     min_distance_q;
	logic [ANGLE_W-1:0]    max_angle_q;
	logic [ANGLE_W-1:0]    angle_jump_q;
	logic [DIST_W-1:0]     distance_jump_q;

	logic [DIST_W-1:0]  dist_prev_q;
	logic [DIST_W-1:0]  dist_pp_q;
	logic [ANGLE_W-1:0] angle_prev_q;
	logic [1:0]         run_count_q;

	logic               fire;
	logic [DIST_W-1:0]  dist_dec;
	logic [DIST_W-1:0]  dp;
	logic [DIST_W-1:0]  dpp;
	logic [ANGLE_W-1:0] ap;
	logic [1:0]         rc;
	logic [1:0]         c_inc;
	logic               pass;
	logic               jump;
	logic               run_ext;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_strength_q  <= MIN_STRENGTH_RST;
			min_distance_q  <= MIN_DISTANCE_RST;
			max_angle_q     <= MAX_ANGLE_RST;
			angle_jump_q    <= ANGLE_JUMP_RST;
			distance_jump_q <= DISTANCE_JUMP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MIN_STRENGTH:  min_strength_q  <= cfg.data[STRENGTH_W-1:0];
				REG_MIN_DISTANCE:  min_distance_q  <= cfg.data;
				REG_MAX_ANGLE:     max_angle_q     <= cfg.data;
				REG_ANGLE_JUMP:    angle_jump_q    <= cfg.data;
				REG_DISTANCE_JUMP: distance_jump_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Accept whenever the queue has room
	assign sample.ready = !q_full;
	assign fire         = sample.valid && !q_full;

	// Decode and classify; a sync clears the filter before the point is seen
	always_comb begin
		dist_dec = (sample.distance_raw << 3) + (sample.distance_raw << 1) - DIST_OFFSET;
		rc      = sample.sync ? 2'd0 : run_count_q;
		dp      = sample.sync ? '0 : dist_prev_q;
		dpp     = sample.sync ? '0 : dist_pp_q;
		ap      = sample.sync ? '0 : angle_prev_q;
		pass    = (sample.strength > min_strength_q) && (sample.angle_raw <= max_angle_q)
		          && (dist_dec >= min_distance_q);
		c_inc   = (rc == 2'd3) ? 2'd3 : rc + 2'd1;
		jump    = (abs_diff16(ap, sample.angle_raw) > angle_jump_q)
		          || (abs_diff16(dp, dist_dec) > distance_jump_q);
		run_ext = c_inc != 2'd1;

		entry.rot_en    = sample.sync;
		entry.rot_has   = run_count_q >= 2'd2;
		entry.rot_dist  = dist_prev_q;
		entry.held_en   = pass && run_ext && jump && (c_inc == 2'd3);
		entry.held_dist = dist_prev_q;
		entry.new_en    = pass && (!run_ext || jump || (c_inc == 2'd3));
		entry.new_avg   = pass && run_ext && !jump && (c_inc == 2'd3);
		entry.new_val   = entry.new_avg ? (SUM_W'(dpp) + SUM_W'(dp) + SUM_W'(dist_dec))
		                                : SUM_W'(dist_dec);
	end

	// Records that produce nothing are not queued
	assign push = fire && (entry.rot_en || entry.held_en || entry.new_en);

	// Filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_prev_q  <= '0;
			dist_pp_q    <= '0;
			angle_prev_q <= '0;
			run_count_q  <= '0;
		end else if (fire) begin
			if (pass) begin
				dist_pp_q    <= dp;
				dist_prev_q  <= dist_dec;
				angle_prev_q <= sample.angle_raw;
				run_count_q  <= (run_ext && jump) ? 2'd0 : c_inc;
			end else if (sample.sync) begin
				dist_pp_q    <= '0;
				dist_prev_q  <= '0;
				angle_prev_q <= '0;
				run_count_q  <= '0;
			end
		end
	end

endmodule

>>> hw/rtl/lsdf_queue.sv
// Command queue between front and back end.
`timescale 1ns / 1ps

module lsdf_queue #(
	parameter int DEPTH = lsdf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lsdf_pkg::lsdf_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output lsdf_pkg::lsdf_entry_t head,
	output logic                  nonempty
);
	import lsdf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lsdf_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign nonempty = count_q != '0;
	assign head     = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("count not raised");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1) else $error("count not lowered");
`endif

endmodule

>>> hw/rtl/lsdf_back.sv
// Back end: unpacks queued commands into result items, divides averages by three.
`timescale 1ns / 1ps

module lsdf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsdf_pkg::lsdf_entry_t head,
	input  logic                  nonempty,
	output logic                  pop,
	lsdf_out_if.source            result
);
	import lsdf_pkg::*;

	localparam int PEND_ROT  = 0;
	localparam int PEND_HELD = 1;
	localparam int PEND_NEW  = 2;

	logic [2:0]        work_pend_q;
	logic              work_rot_has_q;
	logic [DIST_W-1:0] work_rot_dist_q;
	logic [DIST_W-1:0] work_held_q;
	logic [DIST_W-1:0] work_new_q;

	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_has_q;
	logic              out_rot_q;
	logic              out_last_q;

	logic [PROD_W-1:0] prod;
	logic [DIST_W-1:0] new_dist;
	logic              out_free;
	logic              load_out;
	logic [2:0]        pend_after;
	logic [DIST_W-1:0] sel_dist;
	logic              sel_has;
	logic              sel_rot;

	// Divide the three-point sum by reciprocal multiply; registered into work_new_q
	assign prod     = PROD_W'(head.new_val) * PROD_W'(RECIP3);
	assign new_dist = head.new_avg ? prod[RECIP3_SHIFT +: DIST_W] : head.new_val[DIST_W-1:0];

	// Pick the next pending item in order rot, held, new
	always_comb begin
		pend_after = work_pend_q;
		sel_dist   = work_new_q;
		sel_has    = 1'b1;
		sel_rot    = 1'b0;
		if (work_pend_q[PEND_ROT]) begin
			pend_after[PEND_ROT] = 1'b0;
			sel_dist             = work_rot_has_q ? work_rot_dist_q : '0;
			sel_has              = work_rot_has_q;
			sel_rot              = 1'b1;
		end else if (work_pend_q[PEND_HELD]) begin
			pend_after[PEND_HELD] = 1'b0;
			sel_dist              = work_held_q;
		end else begin
			pend_after[PEND_NEW] = 1'b0;
		end
	end

	assign out_free = !out_valid_q || result.ready;
	assign load_out = out_free && (work_pend_q != '0);
	assign pop      = nonempty && ((work_pend_q == '0) || (load_out && (pend_after == '0)));

	// Work register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_pend_q <= '0;
		end else if (pop) begin
			work_pend_q <= {head.new_en, head.held_en, head.rot_en};
		end else if (load_out) begin
			work_pend_q <= pend_after;
		end
	end

	// Work register: payload
	always_ff @(posedge clk) begin
		if (pop) begin
			work_rot_has_q  <= head.rot_has;
			work_rot_dist_q <= head.rot_dist;
			work_held_q     <= head.held_dist;
			work_new_q      <= new_dist;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_dist_q <= sel_dist;
			out_has_q  <= sel_has;
			out_rot_q  <= sel_rot;
			out_last_q <= pend_after == '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.distance_mm  = out_dist_q;
	assign result.has_distance = out_has_q;
	assign result.rotation_end = out_rot_q;
	assign result.last         = out_last_q;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the lidar sample decode and run filter unit.
`timescale 1ns / 1ps

module testbench;
	import lsdf_pkg::*;

	// Indexes past the register file; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_DISTANCE_JUMP + 3'd1;
	localparam logic [DIST_W-1:0]    MM_PER_CM = 16'd10;
	localparam logic [DIST_W-1:0]    MM_OFFSET = 16'd145;
	localparam int STALL_MAX      = 6;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [DIST_W-1:0] dist_mm;
		logic              has;
		logic              rot;
		logic              last;
	} pt_t;

	// One record to send; typed rows carry their expected points
	typedef struct packed {
		logic                  sync;
		logic [ANGLE_W-1:0]    ang;
		logic [DIST_W-1:0]     draw;
		logic [STRENGTH_W-1:0] str;
		logic                  typed;
		logic [1:0]            tn;
		pt_t                   tp0;
		pt_t                   tp1;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	lsdf_in_if  rec_ch();
	lsdf_out_if pt_ch();
	lsdf_cfg_if reg_ch();

	lidar_sample_decode_filter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (rec_ch),
		.result (pt_ch),
		.cfg    (reg_ch)
	);

	always #5 clk = ~clk;

	// Register copies, tracked from accepted register writes
	logic [STRENGTH_W-1:0] lim_str  = MIN_STRENGTH_RST;
	logic [DIST_W-1:0]     lim_dist = MIN_DISTANCE_RST;
	logic [ANGLE_W-1:0]    lim_ang  = MAX_ANGLE_RST;
	logic [ANGLE_W-1:0]    brk_ang  = ANGLE_JUMP_RST;
	logic [DIST_W-1:0]     brk_dist = DISTANCE_JUMP_RST;

	// Run filter history
	logic [DIST_W-1:0]  hist_d1  = '0;
	logic [DIST_W-1:0]  hist_d2  = '0;
	logic [ANGLE_W-1:0] hist_ang = '0;
	logic [1:0]         run_len  = '0;

	pt_t  step_pts[3];
	int   step_n;
	pt_t  due_pts[$];
	pt_t  want_pt;
	pt_t  typed_pt;
	row_t cur_row;
	int   n_errs = 0;
	int   quiet_cycles = 0;
	bit   in_idle_on = 1'b1;
	bit   out_idle_on = 1'b1;
	int   cur_ang = 0;
	int   cur_draw = 300;

	function automatic logic [15:0] gap16(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic void add_pt(input logic [DIST_W-1:0] mm, input logic has,
			input logic rot);
		step_pts[step_n] = '{dist_mm: mm, has: has, rot: rot, last: 1'b0};
		step_n++;
	endfunction

	// Points produced by one record; updates the filter history
	function automatic void filter_record(input logic rot_start, input logic [ANGLE_W-1:0] ang,
			input logic [DIST_W-1:0] draw, input logic [STRENGTH_W-1:0] str);
		logic [DIST_W-1:0] d;
		logic [1:0]        c;
		logic [SUM_W-1:0]  tot;
		logic              brk;
		d = draw * MM_PER_CM - MM_OFFSET;
		step_n = 0;
		// rotation end closes out the run, then the filter starts over
		if (rot_start) begin
			add_pt((run_len >= 2'd2) ? hist_d1 : '0, run_len >= 2'd2, 1'b1);
			hist_d1  = '0;
			hist_d2  = '0;
			hist_ang = '0;
			run_len  = '0;
		end
		if (str > lim_str && ang <= lim_ang && d >= lim_dist) begin
			c = (run_len == 2'd3) ? 2'd3 : run_len + 2'd1;
			if (c == 2'd1) begin
				add_pt(d, 1'b1, 1'b0);
			end else begin
				brk = gap16(hist_ang, ang) > brk_ang || gap16(hist_d1, d) > brk_dist;
				if (brk) begin
					if (c == 2'd3)
						add_pt(hist_d1, 1'b1, 1'b0);
					add_pt(d, 1'b1, 1'b0);
					c = 2'd0;
				end else if (c == 2'd3) begin
					tot = SUM_W'(hist_d2) + SUM_W'(hist_d1) + SUM_W'(d);
					add_pt(DIST_W'(tot / SUM_W'(3)), 1'b1, 1'b0);
				end
			end
			hist_d2  = hist_d1;
			hist_d1  = d;
			hist_ang = ang;
			run_len  = c;
		end
		if (step_n > 0)
			step_pts[step_n-1].last = 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			n_errs++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// Track register writes, predict on record transfers, check result transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (reg_ch.valid && reg_ch.ready) begin
				case (reg_ch.index)
					REG_MIN_STRENGTH:  lim_str  = reg_ch.data[STRENGTH_W-1:0];
					REG_MIN_DISTANCE:  lim_dist = reg_ch.data;
					REG_MAX_ANGLE:     lim_ang  = reg_ch.data;
					REG_ANGLE_JUMP:    brk_ang  = reg_ch.data;
					REG_DISTANCE_JUMP: brk_dist = reg_ch.data;
					default: ;
				endcase
			end
			if (rec_ch.valid && rec_ch.ready) begin
				filter_record(rec_ch.sync, rec_ch.angle_raw, rec_ch.distance_raw,
					rec_ch.strength);
				if (cur_row.typed) begin
					if (cur_row.tn != 2'd0) begin
						typed_pt = cur_row.tp0;
						typed_pt.last = (cur_row.tn == 2'd1);
						due_pts.push_back(typed_pt);
					end
					if (cur_row.tn == 2'd2) begin
						typed_pt = cur_row.tp1;
						typed_pt.last = 1'b1;
						due_pts.push_back(typed_pt);
					end
				end else begin
					for (int i = 0; i < step_n; i++)
						due_pts.push_back(step_pts[i]);
				end
			end
			if (pt_ch.valid && pt_ch.ready) begin
				if (due_pts.size() == 0) begin
					n_errs++;
					$error("result with nothing expected: distance_mm=%0d rotation_end=%0b",
						pt_ch.distance_mm, pt_ch.rotation_end);
				end else begin
					want_pt = due_pts.pop_front();
					check_field("distance_mm", want_pt.dist_mm, pt_ch.distance_mm);
					check_field("has_distance", 16'(want_pt.has), 16'(pt_ch.has_distance));
					check_field("rotation_end", 16'(want_pt.rot), 16'(pt_ch.rotation_end));
					check_field("last", 16'(want_pt.last), 16'(pt_ch.last));
				end
			end
		end
	end

	// Watchdog: too long without any transfer
	always @(posedge clk) begin
		if ((rec_ch.valid && rec_ch.ready) || (pt_ch.valid && pt_ch.ready) ||
				(reg_ch.valid && reg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Result side backpressure in random bursts
	initial begin : sink_side
		int left;
		left = 0;
		pt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!out_idle_on) begin
				left = 0;
				pt_ch.ready <= 1'b1;
			end else if (left > 0) begin
				left--;
				pt_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				left = $urandom_range(0, STALL_MAX - 1);
				pt_ch.ready <= 1'b0;
			end else begin
				pt_ch.ready <= 1'b1;
			end
		end
	end

	function automatic row_t pred_row(input logic s, input logic [15:0] a,
			input logic [15:0] d, input logic [7:0] st);
		row_t r;
		r = '0;
		r.sync = s;
		r.ang  = a;
		r.draw = d;
		r.str  = st;
		return r;
	endfunction

	function automatic row_t typed_row(input logic s, input logic [15:0] a,
			input logic [15:0] d, input logic [7:0] st, input logic [1:0] n,
			input logic [15:0] d0, input logic h0, input logic r0,
			input logic [15:0] d1, input logic h1, input logic r1);
		row_t r;
		r = pred_row(s, a, d, st);
		r.typed = 1'b1;
		r.tn    = n;
		r.tp0   = '{dist_mm: d0, has: h0, rot: r0, last: 1'b0};
		r.tp1   = '{dist_mm: d1, has: h1, rot: r1, last: 1'b0};
		return r;
	endfunction

	// One record transfer, with an optional gap ahead of it
	task automatic send_row(input row_t r);
		if (in_idle_on && $urandom_range(0, 4) == 0) begin
			rec_ch.valid <= 1'b0;
			repeat ($urandom_range(1, STALL_MAX)) @(negedge clk);
		end
		cur_row = r;
		rec_ch.valid        <= 1'b1;
		rec_ch.sync         <= r.sync;
		rec_ch.angle_raw    <= r.ang;
		rec_ch.distance_raw <= r.draw;
		rec_ch.strength     <= r.str;
		do @(posedge clk); while (!rec_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data  <= val;
		do @(posedge clk); while (!reg_ch.ready);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] ms, input logic [15:0] md,
			input logic [15:0] ma, input logic [15:0] aj, input logic [15:0] dj);
		write_reg(REG_MIN_STRENGTH, ms);
		write_reg(REG_MIN_DISTANCE, md);
		write_reg(REG_MAX_ANGLE, ma);
		write_reg(REG_ANGLE_JUMP, aj);
		write_reg(REG_DISTANCE_JUMP, dj);
		write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
		reg_ch.valid <= 1'b0;
	endtask

	// Stop sending and let every pending point and in-flight record drain
	task automatic quiesce();
		rec_ch.valid <= 1'b0;
		while (due_pts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly smooth scans with random content; some noise, jumps and rotation starts
	task automatic gen_record(output row_t r);
		int pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.sync = 1'($urandom_range(0, 1));
			r.ang  = 16'($urandom);
			r.draw = 16'($urandom);
			r.str  = 8'($urandom);
		end else begin
			r.sync = (pick < 14);
			if (r.sync)
				cur_ang = $urandom_range(0, 15);
			else if ($urandom_range(0, 11) == 0)
				cur_ang = $urandom_range(0, 5760);
			else
				cur_ang += $urandom_range(0, 48);
			if (cur_ang > 5760)
				cur_ang = $urandom_range(0, 15);
			if ($urandom_range(0, 9) == 0)
				cur_draw = $urandom_range(40, 6500);
			else
				cur_draw += int'($urandom_range(0, 12)) - 6;
			if (cur_draw < 40)
				cur_draw = 40;
			if (cur_draw > 6500)
				cur_draw = 6500;
			r.ang  = 16'(cur_ang);
			r.draw = 16'(cur_draw);
			if (lim_str == 8'hFF || $urandom_range(0, 9) == 0)
				r.str = 8'($urandom);
			else
				r.str = 8'($urandom_range(int'(lim_str) + 1, 255));
		end
	endtask

	task automatic random_items(input int n);
		row_t r;
		for (int i = 0; i < n; i++) begin
			gen_record(r);
			send_row(r);
		end
	endtask

	initial begin : stim
		row_t dir_rows[$];
		arst_n              = 1'b0;
		rec_ch.valid        = 1'b0;
		rec_ch.sync         = 1'b0;
		rec_ch.angle_raw    = '0;
		rec_ch.distance_raw = '0;
		rec_ch.strength     = '0;
		reg_ch.valid        = 1'b0;
		reg_ch.index        = '0;
		reg_ch.data         = '0;
		cur_row             = '0;

		// Reset defaults: run build-up, averaging, jumps, rejects, wrap, rotation ends
		dir_rows.push_back(typed_row(1, 0, 100, 61, 2, 0, 0, 1, 855, 1, 0));
		dir_rows.push_back(typed_row(0, 16, 101, 255, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(0, 32, 102, 200, 1, 865, 1, 0, 0, 0, 0));
		dir_rows.push_back(pred_row(0, 48, 103, 200));
		// distance jump with a held point
		dir_rows.push_back(typed_row(0, 64, 200, 61, 2, 885, 1, 0, 1855, 1, 0));
		// rejects: strength at the limit, angle, strength zero, distance below limit
		dir_rows.push_back(typed_row(0, 80, 201, 60, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(0, 5761, 201, 255, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(0, 80, 44, 255, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(0, 80, 45, 255, 1, 305, 1, 0, 0, 0, 0));
		// angle jump on the second point, at the largest angle
		dir_rows.push_back(typed_row(0, 5760, 46, 255, 1, 315, 1, 0, 0, 0, 0));
		// decoded distance wraps below zero
		dir_rows.push_back(typed_row(0, 5760, 0, 255, 1, 65391, 1, 0, 0, 0, 0));
		dir_rows.push_back(pred_row(0, 5750, 14, 255));
		dir_rows.push_back(pred_row(0, 5740, 6568, 255));
		// rotation end carrying the last accepted distance
		dir_rows.push_back(typed_row(1, 0, 16'hFFFF, 255, 2, 65535, 1, 1, 65381, 1, 0));
		dir_rows.push_back(pred_row(0, 0, 300, 100));
		dir_rows.push_back(typed_row(0, 10, 301, 100, 1, 2865, 1, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(0, 20, 302, 100, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(1, 30, 303, 100, 2, 2875, 1, 1, 2885, 1, 0));
		// rotation end on a rejected record, short run
		dir_rows.push_back(typed_row(1, 0, 303, 0, 1, 0, 0, 1, 0, 0, 0));
		// jump thresholds: exactly at the limit holds the run
		dir_rows.push_back(pred_row(0, 0, 300, 61));
		dir_rows.push_back(pred_row(0, 2328, 300, 61));
		dir_rows.push_back(pred_row(0, 4656, 320, 61));
		dir_rows.push_back(typed_row(0, 4657, 341, 61, 2, 3055, 1, 0, 3265, 1, 0));
		dir_rows.push_back(pred_row(0, 3000, 341, 61));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_row(dir_rows[i]);

		// Lenient extremes: nonzero strength passes, any angle or distance change breaks the run
		quiesce();
		set_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);
		random_items(30);

		// Strict extremes: only rotation ends come out
		quiesce();
		set_regs(16'd255, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		out_idle_on = 1'b0;
		random_items(15);

		// Random settings
		quiesce();
		set_regs(16'($urandom_range(0, 150)), 16'($urandom_range(0, 3000)),
			16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 3000)),
			16'($urandom_range(0, 600)));
		out_idle_on = 1'b1;
		random_items(25);

		// Runs never break: long averaging stretches, no gaps on either side
		quiesce();
		set_regs(16'd20, 16'd300, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		in_idle_on  = 1'b0;
		out_idle_on = 1'b0;
		random_items(30);

		// Back to defaults, output stalls only
		quiesce();
		set_regs(16'(MIN_STRENGTH_RST), MIN_DISTANCE_RST, MAX_ANGLE_RST, ANGLE_JUMP_RST,
			DISTANCE_JUMP_RST);
		out_idle_on = 1'b1;
		random_items(15);

		// Closing stretch at full rate
		out_idle_on = 1'b0;
		random_items(20);

		quiesce();
		if (n_errs == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/lsdf_pkg.sv
hw/rtl/lsdf_if.sv
hw/rtl/lsdf_front.sv
hw/rtl/lsdf_queue.sv
hw/rtl/lsdf_back.sv
hw/rtl/lidar_sample_decode_filter_unit.sv
verif/testbench.sv
